// File: sv/avt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package avt_pkg;

  localparam int NUM_COEFFS        = 12;
  localparam int FRAC_BITS_DEFAULT = 16;

  localparam logic [1:0] MODE_AFFINE = 2'd0;
  localparam logic [1:0] MODE_ROT    = 2'd1;
  localparam logic [1:0] MODE_ROT_T  = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_w_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  coeff_index;
    word_t       coeff_value;
    word_t       in_x;
    word_t       in_y;
    word_t       in_z;
  } in_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
    word_t out_z;
    logic  saturated;
  } out_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vertex_t;

  // Linear part row-major as lin[r*3+c], translation per row.
  typedef struct packed {
    word_t [8:0] lin;
    word_t [2:0] trans;
  } coef_set_t;

  typedef struct packed {
    prod_w_t [8:0] prod;
    word_t   [2:0] trans;
  } prod_set_t;

endpackage

`default_nettype wire

// File: sv/affine_vertex_transform_core.sv
// out_valid rises once a transform beat has passed four register stages (capture, multiply,
// rounding with partial sums, final sum with saturation). Throughput: one beat per cycle
// while out_ready does not stall the pipe; nine 32x32 multipliers work in parallel in one stage.
// Coefficient write beats produce no output beat.
// Reset is synchronous, active low: identity matrix, zero translation, affine mode, empty pipe.
`timescale 1ns / 1ps
`default_nettype none

module affine_vertex_transform_core #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire avt_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output avt_pkg::out_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_data
);

  logic [1:0]          mode_r, mode_nxt;
  avt_pkg::coef_set_t  coef;
  avt_pkg::vertex_t    vtx;
  avt_pkg::prod_set_t  prod;
  logic                mul_ready, mul_valid, sum_ready;
  logic                coef_wr, xform_valid;

  assign mode_nxt = cfg_we ? cfg_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= avt_pkg::MODE_AFFINE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign in_ready    = mul_ready;
  assign coef_wr     = in_valid && in_ready && (in_data.req_type == avt_pkg::REQ_WRITE);
  assign xform_valid = in_valid && (in_data.req_type == avt_pkg::REQ_XFORM);

  assign vtx.x = in_data.in_x;
  assign vtx.y = in_data.in_y;
  assign vtx.z = in_data.in_z;

  avt_coeff_bank #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (coef_wr),
    .wr_idx (in_data.coeff_index),
    .wr_val (in_data.coeff_value),
    .mode   (mode_r),
    .coef   (coef)
  );

  avt_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (xform_valid),
    .up_ready (mul_ready),
    .up_vtx   (vtx),
    .up_coef  (coef),
    .dn_valid (mul_valid),
    .dn_ready (sum_ready),
    .dn_prod  (prod)
  );

  avt_sum_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_ready (sum_ready),
    .up_prod  (prod),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/avt_coeff_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module avt_coeff_bank #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire logic [3:0]          wr_idx,
  input  wire avt_pkg::word_t      wr_val,
  input  wire logic [1:0]          mode,
  output avt_pkg::coef_set_t       coef
);

  localparam avt_pkg::word_t ONE = avt_pkg::word_t'(32'sd1 <<< FRAC_BITS);

  avt_pkg::word_t matrix_r   [avt_pkg::NUM_COEFFS];
  avt_pkg::word_t matrix_nxt [avt_pkg::NUM_COEFFS];

  always_comb begin
    for (int i = 0; i < avt_pkg::NUM_COEFFS; i++) begin
      matrix_nxt[i] = matrix_r[i];
    end
    // Indexes past the last coefficient are dropped.
    if (wr_en && (wr_idx < 4'(avt_pkg::NUM_COEFFS))) begin
      matrix_nxt[wr_idx] = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < avt_pkg::NUM_COEFFS; i++) begin
        matrix_r[i] <= ((i == 0) || (i == 5) || (i == 10)) ? ONE : '0;
      end
    end else begin
      for (int i = 0; i < avt_pkg::NUM_COEFFS; i++) begin
        matrix_r[i] <= matrix_nxt[i];
      end
    end
  end

  // Any mode other than the two rotation modes acts as affine.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef.lin[r*3+c] = (mode == avt_pkg::MODE_ROT_T) ? matrix_r[c*4+r] : matrix_r[r*4+c];
      end
      coef.trans[r] = ((mode == avt_pkg::MODE_ROT) || (mode == avt_pkg::MODE_ROT_T)) ?
                      '0 : matrix_r[r*4+3];
    end
  end

`ifndef SYNTHESIS
  a_reset_identity: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |->
      (matrix_r[0] == ONE && matrix_r[5] == ONE && matrix_r[10] == ONE &&
       matrix_r[3] == '0 && matrix_r[1] == '0))
    else $error("coefficient bank did not come out of reset as identity");
`endif

endmodule

`default_nettype wire

// File: sv/avt_mul_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module avt_mul_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire avt_pkg::vertex_t    up_vtx,
  input  wire avt_pkg::coef_set_t  up_coef,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output avt_pkg::prod_set_t       dn_prod
);

  logic                s1_v_r, s1_v_nxt;
  avt_pkg::vertex_t    s1_vtx_r;
  avt_pkg::coef_set_t  s1_coef_r;
  logic                s2_v_r, s2_v_nxt;
  avt_pkg::prod_set_t  s2_prod_r, prod_nxt;
  logic                s1_ready, s2_ready;
  avt_pkg::word_t      v [3];

  always_comb begin
    s2_ready = !s2_v_r || dn_ready;
    s1_ready = !s1_v_r || s2_ready;
    s1_v_nxt = s1_ready ? up_valid : s1_v_r;
    s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;
  end

  always_comb begin
    v[0] = s1_vtx_r.x;
    v[1] = s1_vtx_r.y;
    v[2] = s1_vtx_r.z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt.prod[r*3+c] = avt_pkg::prod_w_t'($signed(v[c])) *
                               avt_pkg::prod_w_t'($signed(s1_coef_r.lin[r*3+c]));
      end
    end
    prod_nxt.trans = s1_coef_r.trans;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_vtx_r  <= up_vtx;
      s1_coef_r <= up_coef;
    end
    if (s2_ready && s1_v_r) begin
      s2_prod_r <= prod_nxt;
    end
  end

  assign up_ready = s1_ready;
  assign dn_valid = s2_v_r;
  assign dn_prod  = s2_prod_r;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(s1_vtx_r) && $stable(s1_coef_r)))
    else $error("first multiply stage dropped a stalled beat");
`endif

endmodule

`default_nettype wire

// File: sv/avt_sum_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module avt_sum_stage #(
  parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire avt_pkg::prod_set_t  up_prod,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output avt_pkg::out_t            dn_data
);

  localparam avt_pkg::prod_w_t HALF = avt_pkg::prod_w_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
  localparam avt_pkg::word_t W_MAX = 32'sh7fffffff;
  localparam avt_pkg::word_t W_MIN = 32'sh80000000;

  logic                    s3_v_r, s3_v_nxt;
  logic signed [64:0]      a_r [3];
  logic signed [64:0]      b_r [3];
  logic signed [64:0]      a_nxt [3];
  logic signed [64:0]      b_nxt [3];
  avt_pkg::prod_w_t        rnd [9];
  logic                    out_v_r, out_v_nxt;
  avt_pkg::out_t           out_r, out_nxt;
  logic signed [65:0]      total [3];
  avt_pkg::word_t          res [3];
  logic [2:0]              clip;
  logic                    s3_ready, s4_ready;

  always_comb begin
    s4_ready  = !out_v_r || dn_ready;
    s3_ready  = !s3_v_r || s4_ready;
    s3_v_nxt  = s3_ready ? up_valid : s3_v_r;
    out_v_nxt = s4_ready ? s3_v_r : out_v_r;
  end

  // Adding half an LSB and shifting arithmetically rounds half up toward
  // positive infinity for both signs.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rnd[k] = ($signed(up_prod.prod[k]) + HALF) >>> FRAC_BITS;
    end
    for (int r = 0; r < 3; r++) begin
      a_nxt[r] = 65'(rnd[r*3]) + 65'(rnd[r*3+1]);
      b_nxt[r] = 65'(rnd[r*3+2]) + 65'($signed(up_prod.trans[r]));
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      total[r] = 66'(a_r[r]) + 66'(b_r[r]);
      if (total[r] > SAT_MAX) begin
        res[r]  = W_MAX;
        clip[r] = 1'b1;
      end else if (total[r] < SAT_MIN) begin
        res[r]  = W_MIN;
        clip[r] = 1'b1;
      end else begin
        res[r]  = total[r][31:0];
        clip[r] = 1'b0;
      end
    end
    out_nxt.out_x     = res[0];
    out_nxt.out_y     = res[1];
    out_nxt.out_z     = res[2];
    out_nxt.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && up_valid) begin
      for (int r = 0; r < 3; r++) begin
        a_r[r] <= a_nxt[r];
        b_r[r] <= b_nxt[r];
      end
    end
    if (s4_ready && s3_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign up_ready = s3_ready;
  assign dn_valid = out_v_r;
  assign dn_data  = out_r;

`ifndef SYNTHESIS
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s4_ready) |=> (s3_v_r && $stable(a_r[0]) && $stable(b_r[2])))
    else $error("partial sum stage dropped a stalled beat");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.saturated) |->
      (out_r.out_x == W_MAX || out_r.out_x == W_MIN ||
       out_r.out_y == W_MAX || out_r.out_y == W_MIN ||
       out_r.out_z == W_MAX || out_r.out_z == W_MIN))
    else $error("saturation flag set without a clipped component");
`endif

endmodule

`default_nettype wire
